>>> hdl/semaphore_table_with_wait_queues_macros.svh
// Assertion macros for the semaphore table block.
// Used by the port checker; no other dependencies.
`ifndef SEMAPHORE_TABLE_WITH_WAIT_QUEUES_MACROS_SVH
`define SEMAPHORE_TABLE_WITH_WAIT_QUEUES_MACROS_SVH
// implication checked every clock outside reset
`define STQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define STQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hdl/stq_pkg.sv
// Shared types and codes for the semaphore table block.
// No dependencies.
package stq_pkg;
  localparam logic [1:0] MODE_OPEN   = 2'd0;
  localparam logic [1:0] MODE_WAIT   = 2'd1;
  localparam logic [1:0] MODE_POST   = 2'd2;
  localparam logic [1:0] MODE_UNLINK = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EXISTED  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_QFULL    = 3'd4;

  localparam int CountW = 16;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic scan_clr;   // reset scan pointer and match flags
    logic scan_step;  // compare one entry, advance pointer
    logic rd_ring;    // read ring slot at head
    logic exec;       // apply update, build result
  } stq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // pointer at last entry
    logic need_scan;  // request is open or unlink
    logic need_ring;  // request is a post that may dequeue
  } stq_stat_t;
endpackage

>>> hdl/stq_datapath.sv
// Datapath of the semaphore table: entry storage, scan, ring memory.
// Depends on stq_pkg.
module stq_datapath import stq_pkg::*; #(
  parameter int SEM_COUNT   = 32,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  stq_cmd_t    cmd_i,
  output stq_stat_t   stat_o,
  input  logic [1:0]  mode_i,
  input  logic [63:0] name_key_i,
  input  logic [14:0] initial_value_i,
  input  logic [4:0]  sem_index_i,
  input  logic [5:0]  caller_task_i,
  output logic [2:0]  status_o,
  output logic [4:0]  index_out_o,
  output logic        block_caller_o,
  output logic        wake_valid_o,
  output logic [5:0]  wake_task_o
);
  localparam int IdxW = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
  localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int RingD = SEM_COUNT * QUEUE_DEPTH;
  localparam int RingW = $clog2(RingD);

  logic [SEM_COUNT-1:0]    in_use_q;
  logic [63:0]             name_mem [SEM_COUNT];
  logic signed [CountW-1:0] count_q [SEM_COUNT];
  logic [QW-1:0]           head_q [SEM_COUNT];
  logic [QW-1:0]           tail_q [SEM_COUNT];
  logic [5:0]              ring_mem [RingD];

  logic [1:0]  mode_q;
  logic [63:0] key_q;
  logic [14:0] init_q;
  logic [4:0]  sidx_q;
  logic [5:0]  task_q;
  logic [IdxW-1:0] ptr_q;
  logic        hit_q, free_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  logic [5:0]  ring_rd_q;
  logic [63:0] name_rd;

  logic [IdxW-1:0] sel;
  logic            idx_ok;
  logic signed [CountW-1:0] cnt, cnt_dec, cnt_inc;
  logic [QW-1:0]   hd, tl, tl_nx, hd_nx;

  assign sel    = IdxW'(sidx_q);
  assign idx_ok = ({27'd0, sidx_q} < 32'(SEM_COUNT)) && in_use_q[sel];
  assign cnt    = count_q[sel];
  assign cnt_dec = (cnt != {1'b1, {(CountW-1){1'b0}}}) ? cnt - 1'b1 : cnt;
  assign cnt_inc = (cnt != {1'b0, {(CountW-1){1'b1}}}) ? cnt + 1'b1 : cnt;
  assign hd = head_q[sel];
  assign tl = tail_q[sel];
  assign tl_nx = (tl == QW'(QUEUE_DEPTH-1)) ? '0 : tl + 1'b1;
  assign hd_nx = (hd == QW'(QUEUE_DEPTH-1)) ? '0 : hd + 1'b1;
  assign name_rd = name_mem[ptr_q];

  assign stat_o.scan_last = (ptr_q == IdxW'(SEM_COUNT-1));
  assign stat_o.need_scan = (mode_q == MODE_OPEN) || (mode_q == MODE_UNLINK);
  assign stat_o.need_ring = (mode_q == MODE_POST);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      key_q  <= name_key_i;
      init_q <= initial_value_i;
      sidx_q <= sem_index_i;
      task_q <= caller_task_i;
    end
    if (cmd_i.rd_ring) begin
      ring_rd_q <= ring_mem[RingW'(sel) * RingW'(QUEUE_DEPTH) + RingW'(hd)];
    end
    if (cmd_i.exec && mode_q == MODE_WAIT && idx_ok && cnt_dec < 0 && tl_nx != hd) begin
      ring_mem[RingW'(sel) * RingW'(QUEUE_DEPTH) + RingW'(tl)] <= task_q;
    end
    if (cmd_i.exec && mode_q == MODE_OPEN && !hit_q && free_q) begin
      name_mem[free_idx_q] <= key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      hit_q <= 1'b0;
      free_q <= 1'b0;
      hit_idx_q <= '0;
      free_idx_q <= '0;
      in_use_q <= '0;
    end else begin
      if (cmd_i.scan_clr) begin
        ptr_q <= '0;
        hit_q <= 1'b0;
        free_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        if (!hit_q && in_use_q[ptr_q] && name_rd == key_q) begin
          hit_q <= 1'b1;
          hit_idx_q <= ptr_q;
        end
        if (!free_q && !in_use_q[ptr_q]) begin
          free_q <= 1'b1;
          free_idx_q <= ptr_q;
        end
        if (ptr_q != IdxW'(SEM_COUNT-1)) ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.exec) begin
        if (mode_q == MODE_OPEN && !hit_q && free_q) in_use_q[free_idx_q] <= 1'b1;
        if (mode_q == MODE_UNLINK && hit_q) in_use_q[hit_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_o <= ST_OK;
      index_out_o <= '0;
      block_caller_o <= 1'b0;
      wake_valid_o <= 1'b0;
      wake_task_o <= '0;
      unique case (mode_q)
        MODE_OPEN: begin
          if (hit_q) begin
            status_o <= ST_EXISTED;
            index_out_o <= 5'(hit_idx_q);
          end else if (free_q) begin
            index_out_o <= 5'(free_idx_q);
            count_q[free_idx_q] <= CountW'({1'b0, init_q});
            head_q[free_idx_q] <= '0;
            tail_q[free_idx_q] <= '0;
          end else begin
            status_o <= ST_FULL;
          end
        end
        MODE_UNLINK: begin
          if (hit_q) count_q[hit_idx_q] <= '0;
          else status_o <= ST_NOTFOUND;
        end
        MODE_WAIT: begin
          if (!idx_ok) status_o <= ST_NOTFOUND;
          else begin
            count_q[sel] <= cnt_dec;
            if (cnt_dec < 0) begin
              block_caller_o <= 1'b1;
              if (tl_nx == hd) status_o <= ST_QFULL;
              else tail_q[sel] <= tl_nx;
            end
          end
        end
        default: begin
          if (!idx_ok) status_o <= ST_NOTFOUND;
          else begin
            count_q[sel] <= cnt_inc;
            if (cnt_inc <= 0 && hd != tl) begin
              wake_valid_o <= 1'b1;
              wake_task_o <= ring_rd_q;
              head_q[sel] <= hd_nx;
            end
          end
        end
      endcase
    end
  end
endmodule

>>> hdl/stq_ctrl.sv
// Controller of the semaphore table: sequences scan, ring read and update.
// Depends on stq_pkg.
module stq_ctrl import stq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  stq_stat_t stat_i,
  output stq_cmd_t  cmd_o
);
  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_SCAN, S_RING, S_EXEC, S_OUT} state_e;
  state_e state_q;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o = '0;
    cmd_o.load = (state_q == S_IDLE) && in_valid_i;
    cmd_o.scan_clr = cmd_o.load;
    cmd_o.scan_step = (state_q == S_SCAN);
    cmd_o.rd_ring = (state_q == S_RING);
    cmd_o.exec = (state_q == S_EXEC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE:   if (in_valid_i) state_q <= S_DECODE;
        S_DECODE: begin
          if (stat_i.need_scan) state_q <= S_SCAN;
          else if (stat_i.need_ring) state_q <= S_RING;
          else state_q <= S_EXEC;
        end
        S_SCAN:   if (stat_i.scan_last) state_q <= S_EXEC;
        S_RING:   state_q <= S_EXEC;
        S_EXEC: begin
          state_q <= S_OUT;
          out_valid_o <= 1'b1;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            state_q <= S_IDLE;
            out_valid_o <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/semaphore_table_with_wait_queues.sv
// Top level of the semaphore table with FIFO wait queues.
// Depends on stq_pkg, stq_ctrl and stq_datapath.
// One request is handled at a time. Open and unlink scan the whole table,
// one entry per cycle through a single name-memory read port. Post adds a
// state that reads the ring memory first; wait goes straight to the update.
// A new request is taken in the cycle after its result is accepted, and the
// result is held on the outputs for as long as the receiver stalls.
// Open returns the existing entry for a known name, else claims the lowest
// free entry; counts saturate at 16-bit signed limits; each ring keeps one
// slot empty, holding at most QUEUE_DEPTH-1 tasks. No clearing pass: the
// name, count and ring pointers are written on open before they are read.
module semaphore_table_with_wait_queues import stq_pkg::*; #(
  parameter int SEM_COUNT   = 32,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [63:0] name_key_i,
  input  logic [14:0] initial_value_i,
  input  logic [4:0]  sem_index_i,
  input  logic [5:0]  caller_task_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [4:0]  index_out_o,
  output logic        block_caller_o,
  output logic        wake_valid_o,
  output logic [5:0]  wake_task_o
);
  stq_cmd_t  cmd;
  stq_stat_t stat;

  stq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  stq_datapath #(.SEM_COUNT(SEM_COUNT), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .mode_i, .name_key_i, .initial_value_i, .sem_index_i, .caller_task_i,
    .status_o, .index_out_o, .block_caller_o, .wake_valid_o, .wake_task_o
  );
endmodule

>>> hdl/stq_checker.sv
// Port checker for the semaphore table block, bound to the top level.
// Depends on stq_pkg and the assertion macro header.
`include "semaphore_table_with_wait_queues_macros.svh"
module stq_checker import stq_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o,
  input logic       block_caller_o,
  input logic       wake_valid_o,
  input logic [4:0] index_out_o
);
  `STQ_ASSERT_IMP(a_busy_out, clk_i, rst_ni, out_valid_o, in_stall_o, "input open with result pending")
  `STQ_ASSERT_IMP(a_status_rng, clk_i, rst_ni, out_valid_o, status_o <= ST_QFULL, "bad status code")
  `STQ_ASSERT_IMP(a_excl, clk_i, rst_ni, out_valid_o, !(block_caller_o && wake_valid_o), "block and wake together")
  `STQ_ASSERT_IMP(a_idx_zero, clk_i, rst_ni, out_valid_o && status_o >= ST_FULL, index_out_o == '0, "index set on failed request")
  `STQ_ASSERT_NXT(a_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o && !out_valid_o, "accept did not start work")
endmodule

bind semaphore_table_with_wait_queues stq_checker u_stq_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .status_o, .block_caller_o, .wake_valid_o, .index_out_o
);

>>> tb/semaphore_table_checker.sv
// Checker for the semaphore table block: watches the request and result
// channels, predicts each result and compares it. Depends on stq_pkg.
module semaphore_table_checker import stq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  mode_i,
  input  logic [63:0] name_key_i,
  input  logic [14:0] initial_value_i,
  input  logic [4:0]  sem_index_i,
  input  logic [5:0]  caller_task_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [4:0]  index_out_i,
  input  logic        block_caller_i,
  input  logic        wake_valid_i,
  input  logic [5:0]  wake_task_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEM = 32;
  localparam int QD   = 16;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] index_out;
    logic       block_caller;
    logic       wake_valid;
    logic [5:0] wake_task;
  } sem_reply_t;

  // shadow of the semaphore table
  logic             used_q [NSEM];
  logic [63:0]      key_q  [NSEM];
  logic signed [15:0] cnt_q [NSEM];
  logic [5:0]       ring_q [NSEM][QD];
  logic [3:0]       head_q [NSEM];
  logic [3:0]       tail_q [NSEM];

  sem_reply_t expected_replies[$];

  function automatic int lookup_key(logic [63:0] key);
    for (int i = 0; i < NSEM; i++)
      if (used_q[i] && key_q[i] == key) return i;
    return -1;
  endfunction

  function automatic sem_reply_t apply_request(logic [1:0] mode, logic [63:0] key,
                                               logic [14:0] init, logic [4:0] idx,
                                               logic [5:0] task_id);
    sem_reply_t r;
    int hit;
    logic [3:0] nt;
    r = '0;
    r.status = ST_OK;
    if (mode == MODE_OPEN) begin
      hit = lookup_key(key);
      if (hit >= 0) begin
        r.status = ST_EXISTED;
        r.index_out = hit[4:0];
      end else begin
        r.status = ST_FULL;
        for (int i = 0; i < NSEM; i++) begin
          if (!used_q[i]) begin
            used_q[i] = 1'b1;
            key_q[i] = key;
            cnt_q[i] = {1'b0, init};
            head_q[i] = '0;
            tail_q[i] = '0;
            r.status = ST_OK;
            r.index_out = i[4:0];
            break;
          end
        end
      end
    end else if (mode == MODE_UNLINK) begin
      hit = lookup_key(key);
      if (hit >= 0) begin
        used_q[hit] = 1'b0;
        cnt_q[hit] = '0;
      end else begin
        r.status = ST_NOTFOUND;
      end
    end else if (!used_q[idx]) begin
      r.status = ST_NOTFOUND;
    end else if (mode == MODE_WAIT) begin
      if (cnt_q[idx] != 16'sh8000) cnt_q[idx] = cnt_q[idx] - 16'sd1;
      if (cnt_q[idx] < 0) begin
        r.block_caller = 1'b1;
        nt = tail_q[idx] + 4'd1;
        if (nt == head_q[idx]) begin
          r.status = ST_QFULL;
        end else begin
          ring_q[idx][tail_q[idx]] = task_id;
          tail_q[idx] = nt;
        end
      end
    end else begin
      if (cnt_q[idx] != 16'sh7fff) cnt_q[idx] = cnt_q[idx] + 16'sd1;
      if (cnt_q[idx] <= 0 && head_q[idx] != tail_q[idx]) begin
        r.wake_valid = 1'b1;
        r.wake_task = ring_q[idx][head_q[idx]];
        head_q[idx] = head_q[idx] + 4'd1;
      end
    end
    return r;
  endfunction

  assign pending_o = expected_replies.size();

  always @(posedge clk_i or negedge rst_ni) begin
    sem_reply_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < NSEM; i++) begin
        used_q[i] = 1'b0;
        cnt_q[i] = '0;
        head_q[i] = '0;
        tail_q[i] = '0;
      end
      expected_replies.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected result, nothing pending");
          fail_count_o++;
        end else begin
          exp_r = expected_replies.pop_front();
          if (status_i !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_i);
            fail_count_o++;
          end
          if (index_out_i !== exp_r.index_out) begin
            $error("index_out: expected %0d, got %0d", exp_r.index_out, index_out_i);
            fail_count_o++;
          end
          if (block_caller_i !== exp_r.block_caller) begin
            $error("block_caller: expected %0d, got %0d", exp_r.block_caller,
                   block_caller_i);
            fail_count_o++;
          end
          if (wake_valid_i !== exp_r.wake_valid) begin
            $error("wake_valid: expected %0d, got %0d", exp_r.wake_valid, wake_valid_i);
            fail_count_o++;
          end
          if (wake_task_i !== exp_r.wake_task) begin
            $error("wake_task: expected %0d, got %0d", exp_r.wake_task, wake_task_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_replies.push_back(apply_request(mode_i, name_key_i, initial_value_i,
                                                 sem_index_i, caller_task_i));
    end
  end
endmodule

>>> tb/tb_semaphore_table_with_wait_queues.sv
// Testbench top for the semaphore table block: drives requests and result
// stalls, gives the verdict. Depends on stq_pkg and semaphore_table_checker.
module tb_semaphore_table_with_wait_queues;
  import stq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1760;
  localparam int WATCHDOG_MAX = 20000;
  localparam int DRAIN_CYCLES = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = MODE_OPEN;
  logic [63:0] name_key_i = '0;
  logic [14:0] initial_value_i = '0;
  logic [4:0]  sem_index_i = '0;
  logic [5:0]  caller_task_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [4:0]  index_out_o;
  logic        block_caller_o;
  logic        wake_valid_o;
  logic [5:0]  wake_task_o;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  bit          no_idle;   // long stretch with neither side idling
  bit          finished;

  // small key pool so opens, unlinks and lookups collide often
  logic [63:0] key_pool[8];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  semaphore_table_with_wait_queues dut (.*);

  semaphore_table_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .mode_i, .name_key_i,
    .initial_value_i, .sem_index_i, .caller_task_i, .out_valid_i(out_valid_o),
    .out_stall_i, .status_i(status_o), .index_out_i(index_out_o),
    .block_caller_i(block_caller_o), .wake_valid_i(wake_valid_o),
    .wake_task_i(wake_task_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stalls about a third of the time, except in the quiet stretch
  always @(negedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < 34);
  end

  // watchdog: cycles in a row with nothing accepted
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni && !finished) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // present one request and hold it until accepted; idle gap before it.
  // The block stays busy after an accept until its result has gone out, so the
  // falling edge waited for up front costs no throughput.
  task automatic send_request(logic [1:0] mode, logic [63:0] key, logic [14:0] init,
                              logic [4:0] idx, logic [5:0] task_id);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 34) @(negedge clk_i);
    in_valid_i      <= 1'b1;
    mode_i          <= mode;
    name_key_i      <= key;
    initial_value_i <= init;
    sem_index_i     <= idx;
    caller_task_i   <= task_id;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_random;
    int sel;
    logic [63:0] key;
    sel = $urandom_range(99);
    key = ($urandom_range(9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(7)];
    if (sel < 15)
      send_request(MODE_OPEN, key, ($urandom_range(3) == 0) ? 15'($urandom)
                   : 15'($urandom_range(3)), 5'($urandom), 6'($urandom));
    else if (sel < 22)
      send_request(MODE_UNLINK, key, 15'($urandom), 5'($urandom), 6'($urandom));
    else if (sel < 62)
      send_request(MODE_WAIT, key, 15'($urandom), 5'($urandom_range(9)), 6'($urandom));
    else
      send_request(MODE_POST, key, 15'($urandom), 5'($urandom_range(9)), 6'($urandom));
  endtask

  initial begin
    no_idle = 1'b0;
    finished = 1'b0;
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: extreme keys, free-entry wait/post, saturation at the top,
    // blocking waits up to a full queue, wakeups, post on an empty queue
    send_request(MODE_WAIT, '0, '0, 5'd0, 6'd0);          // not found
    send_request(MODE_POST, '0, '0, 5'd31, 6'd63);        // not found
    send_request(MODE_OPEN, '0, 15'h7fff, 5'd0, 6'd0);    // entry 0, max count
    send_request(MODE_OPEN, '0, 15'd5, 5'd0, 6'd0);       // existed
    send_request(MODE_POST, '0, '0, 5'd0, 6'd0);          // saturates high
    send_request(MODE_UNLINK, '1, '0, 5'd0, 6'd0);        // not found
    send_request(MODE_OPEN, '1, 15'd0, 5'd0, 6'd0);       // entry 1, count 0
    for (int t = 0; t < 16; t++)                          // last one: queue full
      send_request(MODE_WAIT, '1, '0, 5'd1, 6'(t * 4 + 3));
    send_request(MODE_POST, '1, '0, 5'd1, 6'd0);          // wakes task 3
    send_request(MODE_POST, '1, '0, 5'd1, 6'd0);
    send_request(MODE_UNLINK, '0, '0, 5'd0, 6'd0);        // frees entry 0
    send_request(MODE_OPEN, 64'h5555_aaaa_5555_aaaa, 15'h2aaa, 5'd0, 6'd0);
    send_request(MODE_UNLINK, '1, '0, 5'd0, 6'd0);

    // fill the table to see table-full
    for (int i = 0; i < 32; i++)
      send_request(MODE_OPEN, {32'hf0f0_0000, 32'(i)}, 15'(i), 5'd0, 6'd0);
    // pause until everything outstanding has come back
    wait (pending == 0);
    for (int i = 0; i < 32; i++)
      send_request(MODE_UNLINK, {32'hf0f0_0000, 32'(i)}, '0, 5'd0, 6'd0);
    send_request(MODE_UNLINK, 64'h5555_aaaa_5555_aaaa, '0, 5'd0, 6'd0);

    // random part; a stretch in the middle runs with no idling at all
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 600 && n < 850);
      send_random();
    end
    no_idle = 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    finished = 1'b1;
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
